FILE: sv/rclfp_pkg.sv
`timescale 1ns / 1ps

package rclfp_pkg;

    // Frame store depth and number of unpacked channels.
    localparam int FRAME_DEPTH  = 64;
    localparam int NUM_CHANNELS = 14;

    localparam int ADDR_W = $clog2(FRAME_DEPTH);
    localparam int LEN_W  = $clog2(FRAME_DEPTH + 1);
    // Width for comparing lengths against bytes and register fields.
    localparam int CMP_W  = ((LEN_W > 8) ? LEN_W : 8) + 1;

    localparam int CHAN_BITS        = 11;
    localparam int RC_PAYLOAD_BYTES = 22;
    localparam int MIN_LEN          = 2;
    localparam int BYTES_PER_CHAN   = 3;

    localparam logic [7:0] CRC_POLY    = 8'hD5;
    localparam logic [7:0] QUAL_RESET  = 8'hFF;

    localparam logic [7:0] RST_SYNC_BYTE = 8'd200;
    localparam logic [6:0] RST_MAX_LEN   = 7'd62;
    localparam logic [7:0] RST_RC_TYPE   = 8'd22;
    localparam logic [7:0] RST_LS_TYPE   = 8'd20;
    localparam logic [5:0] RST_LS_SIZE   = 6'd10;
    localparam logic [5:0] RST_QUAL_OFS  = 6'd2;

    typedef enum logic [1:0] {
        KIND_CHAN       = 2'd0,
        KIND_CRC_ERR    = 2'd1,
        KIND_LINK_STATS = 2'd2,
        KIND_OTHER      = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_SYNC_BYTE = 3'd0,
        CFG_MAX_LEN   = 3'd1,
        CFG_RC_TYPE   = 3'd2,
        CFG_LS_TYPE   = 3'd3,
        CFG_LS_SIZE   = 3'd4,
        CFG_QUAL_OFS  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_SYNC,
        ST_LEN,
        ST_BODY,
        ST_PUT_ERR,
        ST_OTHER,
        ST_PUT_OTHER,
        ST_LS_RD,
        ST_LS_UPD,
        ST_PUT_LS,
        ST_CH_RD,
        ST_CH_WAIT,
        ST_CH_PUT
    } t_state;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [6:0] max_len;
        logic [7:0] rc_type;
        logic [7:0] ls_type;
        logic [5:0] ls_size;
        logic [5:0] qual_ofs;
    } t_cfg;

    typedef struct packed {
        logic  len_load;
        logic  body_wr;
        logic  rd_issue;
        logic  q_read;
        logic  count;
        logic  q_upd;
        logic  put;
        t_kind put_kind;
        logic  ch_next;
    } t_cmd;

    typedef struct packed {
        logic is_sync;
        logic len_ok;
        logic body_last;
        logic crc_ok;
        logic is_rc;
        logic is_ls;
        logic j_last;
        logic k_last;
        logic out_free;
    } t_sts;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] v;
        v = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

FILE: sv/rclfp_dp.sv
`timescale 1ns / 1ps

module rclfp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rclfp_pkg::t_cfg    i_cfg,
    input  rclfp_pkg::t_cmd    i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic               i_out_stall,
    output rclfp_pkg::t_sts    o_sts,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [3:0]         o_channel_index,
    output logic [10:0]        o_channel_value,
    output logic               o_failsafe,
    output logic [7:0]         o_link_quality,
    output logic [31:0]        o_frames_counted,
    output logic               o_last
);
    import rclfp_pkg::*;

    logic [7:0]       r_store [FRAME_DEPTH];
    logic [7:0]       r_mem_q;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_cnt;
    logic [7:0]       r_crc;
    logic [7:0]       r_type;
    logic [7:0]       r_quality;
    logic [31:0]      r_frames;
    logic [3:0]       r_k;
    logic [1:0]       r_j;
    logic             r_rd_pend;
    logic             r_rd_zero;
    logic [23:0]      r_w;

    logic             r_o_valid;
    logic [1:0]       r_o_kind;
    logic [3:0]       r_o_index;
    logic [10:0]      r_o_value;
    logic             r_o_failsafe;
    logic [7:0]       r_o_quality;
    logic [31:0]      r_o_frames;
    logic             r_o_last;

    logic [CMP_W-1:0]  byte_x;
    logic [CMP_W-1:0]  plen;
    logic              body_last;
    logic              k_last;
    logic              qual_in;
    logic [7:0]        pos;
    logic [7:0]        byte_idx;
    logic              rd_zero;
    logic [ADDR_W-1:0] ch_addr;
    logic [ADDR_W-1:0] q_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAN_BITS-1:0] ch_val;

    always_comb begin
        byte_x    = CMP_W'(i_data_byte);
        plen      = CMP_W'(r_len) - CMP_W'(MIN_LEN);
        body_last = (r_cnt + LEN_W'(1)) == r_len;
        k_last    = r_k == 4'(NUM_CHANNELS - 1);
        qual_in   = CMP_W'(i_cfg.qual_ofs) < plen;

        // Channel k starts at bit 11*k of the payload; payload byte b sits at store b+1.
        pos      = 8'(r_k) * 8'(CHAN_BITS);
        byte_idx = (pos >> 3) + 8'(r_j);
        rd_zero  = byte_idx >= 8'(RC_PAYLOAD_BYTES);
        ch_addr  = ADDR_W'(byte_idx + 8'd1);
        q_addr   = ADDR_W'(CMP_W'(i_cfg.qual_ofs) + CMP_W'(1));
        rd_addr  = i_cmd.q_read ? q_addr : ch_addr;
        wr_addr  = r_cnt[ADDR_W-1:0];
        ch_val   = CHAN_BITS'(r_w >> pos[2:0]);

        o_sts.is_sync   = i_data_byte == i_cfg.sync_byte;
        o_sts.len_ok    = (byte_x >= CMP_W'(MIN_LEN)) && (byte_x <= CMP_W'(i_cfg.max_len))
                          && (byte_x <= CMP_W'(FRAME_DEPTH));
        o_sts.body_last = body_last;
        o_sts.crc_ok    = r_crc == i_data_byte;
        o_sts.is_rc     = (r_type == i_cfg.rc_type) && (plen == CMP_W'(RC_PAYLOAD_BYTES));
        o_sts.is_ls     = (r_type == i_cfg.ls_type) && (plen == CMP_W'(i_cfg.ls_size));
        o_sts.j_last    = r_j == 2'(BYTES_PER_CHAN - 1);
        o_sts.k_last    = k_last;
        o_sts.out_free  = !r_o_valid || !i_out_stall;
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.body_wr) begin
            r_store[wr_addr] <= i_data_byte;
        end
        if (i_cmd.rd_issue || i_cmd.q_read) begin
            r_mem_q <= r_store[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_cnt     <= '0;
            r_crc     <= '0;
            r_quality <= QUAL_RESET;
            r_frames  <= '0;
            r_k       <= '0;
            r_j       <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.len_load) begin
                r_len <= LEN_W'(i_data_byte);
                r_cnt <= '0;
                r_crc <= '0;
            end
            if (i_cmd.body_wr) begin
                r_cnt <= r_cnt + LEN_W'(1);
                if (!body_last) begin
                    r_crc <= crc8_step(r_crc, i_data_byte);
                end
                r_k <= '0;
                r_j <= '0;
            end
            if (i_cmd.rd_issue) begin
                r_j <= r_j + 2'd1;
            end
            if (i_cmd.ch_next) begin
                r_k <= r_k + 4'd1;
                r_j <= '0;
            end
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.count && (r_frames != '1)) begin
                r_frames <= r_frames + 32'd1;
            end
            if (i_cmd.q_upd && qual_in) begin
                r_quality <= r_mem_q;
            end
            if (i_cmd.put) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.body_wr && (r_cnt == '0)) begin
            r_type <= i_data_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_zero <= rd_zero;
        end
        // Bytes arrive low first and shift down, so three captures leave {b2, b1, b0}.
        if (r_rd_pend) begin
            r_w <= {(r_rd_zero ? 8'd0 : r_mem_q), r_w[23:8]};
        end
        if (i_cmd.put) begin
            r_o_kind     <= i_cmd.put_kind;
            r_o_index    <= (i_cmd.put_kind == KIND_CHAN) ? r_k : 4'd0;
            r_o_value    <= (i_cmd.put_kind == KIND_CHAN) ? ch_val : '0;
            r_o_failsafe <= r_quality == 8'd0;
            r_o_quality  <= r_quality;
            r_o_frames   <= r_frames;
            r_o_last     <= (i_cmd.put_kind != KIND_CHAN) || k_last;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_kind           = r_o_kind;
    assign o_channel_index  = r_o_index;
    assign o_channel_value  = r_o_value;
    assign o_failsafe       = r_o_failsafe;
    assign o_link_quality   = r_o_quality;
    assign o_frames_counted = r_o_frames;
    assign o_last           = r_o_last;

endmodule

FILE: sv/rclfp_ctrl.sv
`timescale 1ns / 1ps

module rclfp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  rclfp_pkg::t_sts i_sts,
    output rclfp_pkg::t_cmd o_cmd,
    output logic            o_in_stall
);
    import rclfp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SYNC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SYNC: begin
                if (i_in_valid && i_sts.is_sync) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (i_in_valid) begin
                    n_state = i_sts.len_ok ? ST_BODY : ST_SYNC;
                end
            end
            ST_BODY: begin
                if (i_in_valid && i_sts.body_last) begin
                    if (!i_sts.crc_ok) begin
                        n_state = ST_PUT_ERR;
                    end else if (i_sts.is_rc) begin
                        n_state = ST_CH_RD;
                    end else if (i_sts.is_ls) begin
                        n_state = ST_LS_RD;
                    end else begin
                        n_state = ST_OTHER;
                    end
                end
            end
            ST_PUT_ERR, ST_PUT_OTHER, ST_PUT_LS: begin
                if (i_sts.out_free) begin
                    n_state = ST_SYNC;
                end
            end
            ST_OTHER:   n_state = ST_PUT_OTHER;
            ST_LS_RD:   n_state = ST_LS_UPD;
            ST_LS_UPD:  n_state = ST_PUT_LS;
            ST_CH_RD: begin
                if (i_sts.j_last) begin
                    n_state = ST_CH_WAIT;
                end
            end
            ST_CH_WAIT: n_state = ST_CH_PUT;
            ST_CH_PUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.k_last ? ST_SYNC : ST_CH_RD;
                end
            end
            default:    n_state = ST_SYNC;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_SYNC: begin
                o_in_stall = 1'b0;
            end
            ST_LEN: begin
                o_in_stall     = 1'b0;
                o_cmd.len_load = i_in_valid && i_sts.len_ok;
            end
            ST_BODY: begin
                o_in_stall    = 1'b0;
                o_cmd.body_wr = i_in_valid;
            end
            ST_PUT_ERR: begin
                o_cmd.put      = i_sts.out_free;
                o_cmd.put_kind = KIND_CRC_ERR;
            end
            ST_OTHER: begin
                o_cmd.count = 1'b1;
            end
            ST_PUT_OTHER: begin
                o_cmd.put      = i_sts.out_free;
                o_cmd.put_kind = KIND_OTHER;
            end
            ST_LS_RD: begin
                o_cmd.q_read = 1'b1;
                o_cmd.count  = 1'b1;
            end
            ST_LS_UPD: begin
                o_cmd.q_upd = 1'b1;
            end
            ST_PUT_LS: begin
                o_cmd.put      = i_sts.out_free;
                o_cmd.put_kind = KIND_LINK_STATS;
            end
            ST_CH_RD: begin
                o_cmd.rd_issue = 1'b1;
            end
            ST_CH_WAIT: begin
                o_cmd = '0;
            end
            ST_CH_PUT: begin
                o_cmd.put      = i_sts.out_free;
                o_cmd.put_kind = KIND_CHAN;
                o_cmd.ch_next  = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: sv/rc_link_frame_parser.sv
`timescale 1ns / 1ps

// Serial RC link frame parser. Received bytes enter on the input channel
// (i_in_valid, o_in_stall, i_data_byte); one transfer carries one byte. The block
// hunts for the sync byte, reads a length byte, then collects type, payload and
// CRC-8 (poly 0xD5) into a 64-byte frame store. Results leave on the output
// channel (o_out_valid, i_out_stall) from an output register; o_last marks the
// final result of a frame. Configuration registers are written through
// i_cfg_we / i_cfg_index / i_cfg_data, one register per cycle; the user must write
// them only while no frame is being received and no result is pending, as the
// block itself does not enforce this. Throughput: one byte per cycle while a
// frame is being received. After the final byte the input stalls while results
// are produced: an output step for a CRC error; a count step and an output step
// for another valid frame; a quality read, a quality update and an output step
// for link statistics; and three store reads, one read wait and one output step
// per 11-bit channel of an RC frame, all 14 of them. Each result is valid on the
// output from the edge that ends its step; a stall holds the pending result and
// the sequencer. Reset (synchronous, active low) restores register defaults,
// sets link quality to 255, clears the frame counter and returns to sync hunting.

module rc_link_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_channel_index,
    output logic [10:0] o_channel_value,
    output logic        o_failsafe,
    output logic [7:0]  o_link_quality,
    output logic [31:0] o_frames_counted,
    output logic        o_last
);
    import rclfp_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    // Register file; indexes beyond the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte <= RST_SYNC_BYTE;
            r_cfg.max_len   <= RST_MAX_LEN;
            r_cfg.rc_type   <= RST_RC_TYPE;
            r_cfg.ls_type   <= RST_LS_TYPE;
            r_cfg.ls_size   <= RST_LS_SIZE;
            r_cfg.qual_ofs  <= RST_QUAL_OFS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SYNC_BYTE: r_cfg.sync_byte <= i_cfg_data;
                CFG_MAX_LEN:   r_cfg.max_len   <= i_cfg_data[6:0];
                CFG_RC_TYPE:   r_cfg.rc_type   <= i_cfg_data;
                CFG_LS_TYPE:   r_cfg.ls_type   <= i_cfg_data;
                CFG_LS_SIZE:   r_cfg.ls_size   <= i_cfg_data[5:0];
                CFG_QUAL_OFS:  r_cfg.qual_ofs  <= i_cfg_data[5:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Sequencer: frame phases and the result generation steps.
    rclfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Frame store, CRC, link state, channel unpacking and the output register.
    rclfp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .i_data_byte      (i_data_byte),
        .i_out_stall      (i_out_stall),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_channel_index  (o_channel_index),
        .o_channel_value  (o_channel_value),
        .o_failsafe       (o_failsafe),
        .o_link_quality   (o_link_quality),
        .o_frames_counted (o_frames_counted),
        .o_last           (o_last)
    );

endmodule
